// File: rtl/core/srsv_pkg.sv
// Shared types and constants for the snapshot record stream validator.
package srsv_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned WORD_BYTES  = 2;
   localparam int unsigned EVENT_SHIFT = 3;   // eight payload bytes per event
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned REC_CNT_W   = 32;
   localparam int unsigned EVENTS_W    = 16;
   localparam int unsigned HDR_IDX_W   = 6;
   localparam int unsigned PAYLOAD_W   = 20;

   localparam logic [CSR_INDEX_W-1:0] CSR_RECORD_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_EVENTS   = 1'b1;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1
   } phase_type;

   typedef enum logic [2:0] {
      ERR_NONE          = 3'd0,
      ERR_SHORT_HEADER  = 3'd1,
      ERR_KEY_LEN       = 3'd2,
      ERR_EVENTS        = 3'd3,
      ERR_SHORT_PAYLOAD = 3'd4,
      ERR_TRAILING      = 3'd5
   } error_type;

   typedef struct packed {
      logic              has_byte;
      logic [BYTE_W-1:0] data_byte;
      logic              end_of_buffer;
   } item_type;

   typedef struct packed {
      logic      verdict_ok;
      error_type error_reason;
   } verdict_type;

endpackage

// File: rtl/core/srsv_check.sv
// Record parsing and verdict: one byte transaction per cycle with step set.
module srsv_check #(
   parameter int unsigned HEADER_BYTES = 8,
   parameter int unsigned KEY_BYTES    = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  srsv_pkg::item_type                  item,
   input  logic [srsv_pkg::REC_CNT_W-1:0]      record_count,
   input  logic [srsv_pkg::EVENTS_W-1:0]       max_events,
   output srsv_pkg::verdict_type               verdict
);

   localparam int unsigned IW = srsv_pkg::HDR_IDX_W;
   localparam int unsigned PW = srsv_pkg::PAYLOAD_W;
   localparam int unsigned EW = srsv_pkg::EVENTS_W;
   localparam int unsigned RW = srsv_pkg::REC_CNT_W;

   localparam logic [IW-1:0] IDX_KEY_LO = IW'(0);
   localparam logic [IW-1:0] IDX_KEY_HI = IW'(1);
   localparam logic [IW-1:0] IDX_CNT_LO = IW'(srsv_pkg::WORD_BYTES);
   localparam logic [IW-1:0] IDX_CNT_HI = IW'(srsv_pkg::WORD_BYTES + 1);
   localparam logic [IW:0]   HDR_LEN    = (IW+1)'(HEADER_BYTES);
   localparam logic [EW-1:0] KEY_LEN    = EW'(KEY_BYTES);

   srsv_pkg::phase_type phase_ff, phase_in;
   srsv_pkg::error_type first_error_ff, first_error_in;
   logic [IW-1:0] header_index_ff, header_index_in;
   logic [EW-1:0] key_length_ff, key_length_in;
   logic [EW-1:0] event_count_ff, event_count_in;
   logic [PW-1:0] payload_left_ff, payload_left_in;
   logic [RW-1:0] records_done_ff, records_done_in;

   logic [IW:0]   hdr_next;
   logic [PW-1:0] left_dec;
   logic [PW-1:0] total;

   // Next state after the byte of this transaction, if any.
   always_comb begin
      phase_in        = phase_ff;
      first_error_in  = first_error_ff;
      header_index_in = header_index_ff;
      key_length_in   = key_length_ff;
      event_count_in  = event_count_ff;
      payload_left_in = payload_left_ff;
      records_done_in = records_done_ff;
      hdr_next        = {1'b0, header_index_ff} + (IW+1)'(1);
      left_dec        = payload_left_ff - PW'(1);
      total           = '0;

      if (item.has_byte && (first_error_ff == srsv_pkg::ERR_NONE)) begin
         if (phase_ff == srsv_pkg::PH_PAYLOAD) begin
            payload_left_in = left_dec;
            if (left_dec == '0) begin
               records_done_in = records_done_ff + RW'(1);
               phase_in        = srsv_pkg::PH_HEADER;
               header_index_in = '0;
            end
         end else if ((header_index_ff == '0) && (records_done_ff >= record_count)) begin
            first_error_in = srsv_pkg::ERR_TRAILING;
         end else begin
            case (header_index_ff)
               IDX_KEY_LO: key_length_in[7:0]   = item.data_byte;
               IDX_KEY_HI: key_length_in[15:8]  = item.data_byte;
               IDX_CNT_LO: event_count_in[7:0]  = item.data_byte;
               IDX_CNT_HI: event_count_in[15:8] = item.data_byte;
               default: ;
            endcase
            total = PW'(key_length_in) + (PW'(event_count_in) << srsv_pkg::EVENT_SHIFT);
            if (hdr_next >= HDR_LEN) begin
               header_index_in = '0;
               if (key_length_in != KEY_LEN) begin
                  first_error_in = srsv_pkg::ERR_KEY_LEN;
               end else if (event_count_in > max_events) begin
                  first_error_in = srsv_pkg::ERR_EVENTS;
               end else begin
                  payload_left_in = total;
                  if (total == '0) begin
                     records_done_in = records_done_ff + RW'(1);
                  end else begin
                     phase_in = srsv_pkg::PH_PAYLOAD;
                  end
               end
            end else begin
               header_index_in = hdr_next[IW-1:0];
            end
         end
      end
   end

   // Verdict as seen after this transaction's byte.
   always_comb begin
      verdict.error_reason = first_error_in;
      if (first_error_in == srsv_pkg::ERR_NONE) begin
         if (phase_in == srsv_pkg::PH_PAYLOAD) begin
            verdict.error_reason = srsv_pkg::ERR_SHORT_PAYLOAD;
         end else if ((header_index_in != '0) || (records_done_in < record_count)) begin
            verdict.error_reason = srsv_pkg::ERR_SHORT_HEADER;
         end
      end
      verdict.verdict_ok = (verdict.error_reason == srsv_pkg::ERR_NONE);
   end

   // Rearm on reset and after the end marker.
   always_ff @(posedge clock) begin
      if (reset || (step && item.end_of_buffer)) begin
         phase_ff        <= srsv_pkg::PH_HEADER;
         first_error_ff  <= srsv_pkg::ERR_NONE;
         header_index_ff <= '0;
         key_length_ff   <= '0;
         event_count_ff  <= '0;
         payload_left_ff <= '0;
         records_done_ff <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         first_error_ff  <= first_error_in;
         header_index_ff <= header_index_in;
         key_length_ff   <= key_length_in;
         event_count_ff  <= event_count_in;
         payload_left_ff <= payload_left_in;
         records_done_ff <= records_done_in;
      end
   end

endmodule

// File: rtl/core/snapshot_record_stream_validator_core.sv
// Top level of the snapshot record stream validator.
//
// Input stream (req_): one transaction per snapshot byte. tdata carries the
// byte, tuser says whether the byte is present, tlast marks the end of the
// buffer. A transaction with tlast produces exactly one result transaction
// on rsp_: bit 0 is the pass flag, bits 3:1 the reason of the first error.
// Other transactions produce no result.
// Registers are written through csr_ while the stream is idle: the user must keep to
// this, the block does not enforce it. Index 0 holds the expected record count, index 1
// the largest event count per record. A result passes through the input register, then
// the result register; an end transaction waits in the input register while the result
// register is occupied and rsp_tready is low. Throughput is one transaction per cycle
// except while such an end transaction waits; the per-byte update is combinational logic
// between the input register and the parser state. Reset clears the parser state, the
// registers and the valid flags of both pipeline stages. When rsp_tready is low a held
// result stalls only the next end transaction; ordinary bytes keep flowing.
module snapshot_record_stream_validator_core #(
   parameter int unsigned HEADER_BYTES = 8,
   parameter int unsigned KEY_BYTES    = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,  // data_byte
   input  logic                                  req_tuser,  // has_byte
   input  logic                                  req_tlast,  // end_of_buffer
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [7:0]                            rsp_tdata,  // verdict_ok, error_reason[2:0]
   input  logic                                  csr_we,
   input  logic [srsv_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [srsv_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   logic [srsv_pkg::REC_CNT_W-1:0] record_count_ff, record_count_in;
   logic [srsv_pkg::EVENTS_W-1:0]  max_events_ff, max_events_in;

   srsv_pkg::item_type    stage_ff, stage_in;
   logic                  stage_valid_ff, stage_valid_in;
   srsv_pkg::verdict_type out_ff, out_in;
   logic                  out_valid_ff, out_valid_in;
   srsv_pkg::verdict_type verdict;
   logic                  consume;

   always_comb begin
      record_count_in = record_count_ff;
      max_events_in   = max_events_ff;
      if (csr_we) begin
         case (csr_index)
            srsv_pkg::CSR_RECORD_COUNT: record_count_in = csr_wdata;
            srsv_pkg::CSR_MAX_EVENTS:   max_events_in = csr_wdata[srsv_pkg::EVENTS_W-1:0];
            default: ;
         endcase
      end
   end

   // An end transaction waits while the result register is occupied and rsp_tready is low.
   assign consume    = stage_valid_ff &&
                       (!stage_ff.end_of_buffer || !out_valid_ff || rsp_tready);
   assign req_tready = !stage_valid_ff || consume;

   always_comb begin
      stage_in.has_byte      = req_tuser;
      stage_in.data_byte     = req_tdata;
      stage_in.end_of_buffer = req_tlast;
      if (req_tvalid && req_tready) begin
         stage_valid_in = 1'b1;
      end else if (consume) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (consume && stage_ff.end_of_buffer) begin
         out_in       = verdict;
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   srsv_check #(
      .HEADER_BYTES (HEADER_BYTES),
      .KEY_BYTES    (KEY_BYTES)
   ) u_check (
      .clock        (clock),
      .reset        (reset),
      .step         (consume),
      .item         (stage_ff),
      .record_count (record_count_ff),
      .max_events   (max_events_ff),
      .verdict      (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         record_count_ff <= '0;
         max_events_ff   <= '0;
         stage_valid_ff  <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         record_count_ff <= record_count_in;
         max_events_ff   <= max_events_in;
         stage_valid_ff  <= stage_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   // Payload registers: hold while stalled.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         stage_ff <= stage_in;
      end
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_ff.error_reason, out_ff.verdict_ok};

endmodule

// File: tb/srsv_checker.sv
// Checker for the snapshot validator: mirrors the parser and checks every verdict.
`timescale 1ns / 1ps

module srsv_checker #(
   parameter int unsigned HEADER_BYTES = 8,
   parameter int unsigned KEY_BYTES    = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // data_byte
   input  logic                                req_tuser,  // has_byte
   input  logic                                req_tlast,  // end_of_buffer
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [7:0]                          rsp_tdata,  // verdict_ok, error_reason[2:0]
   input  logic                                csr_we,
   input  logic [srsv_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [srsv_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                  fail_count,
   output int                                  pending,
   output int                                  verdicts,
   output int                                  passes
);

   localparam int unsigned PW = srsv_pkg::PAYLOAD_W;

   // register copies
   logic [srsv_pkg::REC_CNT_W-1:0]  rec_limit;
   logic [srsv_pkg::EVENTS_W-1:0]   evt_limit;

   // parser copy
   srsv_pkg::phase_type             parse_phase;
   logic [srsv_pkg::HDR_IDX_W-1:0]  hdr_idx;
   logic [15:0]                     key_len;
   logic [15:0]                     evt_cnt;
   logic [PW-1:0]                   payload_left;
   logic [srsv_pkg::REC_CNT_W-1:0]  recs_done;
   srsv_pkg::error_type             first_err;

   srsv_pkg::verdict_type           verdict_q[$];

   task automatic rearm_parser();
      parse_phase  = srsv_pkg::PH_HEADER;
      hdr_idx      = '0;
      key_len      = '0;
      evt_cnt      = '0;
      payload_left = '0;
      recs_done    = '0;
      first_err    = srsv_pkg::ERR_NONE;
   endtask

   task automatic absorb_byte(input logic [7:0] b);
      logic [srsv_pkg::HDR_IDX_W-1:0] next_idx;
      if (first_err != srsv_pkg::ERR_NONE) return;
      if (parse_phase == srsv_pkg::PH_PAYLOAD) begin
         payload_left = payload_left - 1'b1;
         if (payload_left == '0) begin
            recs_done   = recs_done + 1'b1;
            parse_phase = srsv_pkg::PH_HEADER;
            hdr_idx     = '0;
         end
         return;
      end
      // a new header with every record already seen is a trailing byte
      if (hdr_idx == '0 && recs_done >= rec_limit) begin
         first_err = srsv_pkg::ERR_TRAILING;
         return;
      end
      if (hdr_idx == 0)
         key_len[7:0] = b;
      else if (hdr_idx == 1)
         key_len[15:8] = b;
      else if (hdr_idx == srsv_pkg::WORD_BYTES)
         evt_cnt[7:0] = b;
      else if (hdr_idx == srsv_pkg::WORD_BYTES + 1)
         evt_cnt[15:8] = b;
      next_idx = hdr_idx + 1'b1;
      if (next_idx >= HEADER_BYTES || next_idx == '0) begin
         hdr_idx = '0;
         if (32'(key_len) != KEY_BYTES) begin
            first_err = srsv_pkg::ERR_KEY_LEN;
            return;
         end
         if (evt_cnt > evt_limit) begin
            first_err = srsv_pkg::ERR_EVENTS;
            return;
         end
         payload_left = PW'(32'(key_len) +
                            (32'(evt_cnt) << srsv_pkg::EVENT_SHIFT));
         if (payload_left == '0)
            recs_done = recs_done + 1'b1;
         else
            parse_phase = srsv_pkg::PH_PAYLOAD;
      end else begin
         hdr_idx = next_idx;
      end
   endtask

   task automatic close_buffer();
      srsv_pkg::error_type   reason;
      srsv_pkg::verdict_type want;
      reason = first_err;
      if (reason == srsv_pkg::ERR_NONE) begin
         if (parse_phase == srsv_pkg::PH_PAYLOAD)
            reason = srsv_pkg::ERR_SHORT_PAYLOAD;
         else if (hdr_idx != '0 || recs_done < rec_limit)
            reason = srsv_pkg::ERR_SHORT_HEADER;
      end
      want.verdict_ok   = (reason == srsv_pkg::ERR_NONE);
      want.error_reason = reason;
      verdict_q.push_back(want);
      rearm_parser();
   endtask

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      srsv_pkg::verdict_type want;
      if (reset) begin
         rec_limit  = '0;
         evt_limit  = '0;
         rearm_parser();
         verdict_q.delete();
         fail_count = 0;
         verdicts   = 0;
         passes     = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_q.size() == 0) begin
               note_failure($sformatf("result with no verdict pending, tdata=%h", rsp_tdata));
            end else begin
               want = verdict_q.pop_front();
               if (rsp_tdata[0] !== want.verdict_ok ||
                   rsp_tdata[3:1] !== want.error_reason || rsp_tdata[7:4] !== 4'h0)
                  note_failure($sformatf({"verdict: expected ok=%0d reason=%0d, ",
                                          "got ok=%0d reason=%0d (tdata=%h)"},
                                         want.verdict_ok, want.error_reason,
                                         rsp_tdata[0], rsp_tdata[3:1], rsp_tdata));
               verdicts++;
               if (want.verdict_ok) passes++;
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser) absorb_byte(req_tdata);
            if (req_tlast) close_buffer();
         end
         if (csr_we) begin
            case (csr_index)
               srsv_pkg::CSR_RECORD_COUNT:
                  rec_limit = csr_wdata[srsv_pkg::REC_CNT_W-1:0];
               srsv_pkg::CSR_MAX_EVENTS:
                  evt_limit = csr_wdata[srsv_pkg::EVENTS_W-1:0];
               default: ;
            endcase
         end
      end
      pending = verdict_q.size();
   end

endmodule

// File: tb/tb.sv
// Testbench top: drives snapshot buffers and register settings, reports the verdict.
`timescale 1ns / 1ps

module tb;

   localparam int unsigned HEADER_BYTES = 8;
   localparam int unsigned KEY_BYTES    = 32;
   localparam int          RANDOM_ITEMS = 1350;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          IDLE_PCT     = 35;

   typedef enum int {FLAW_NONE, FLAW_KEY, FLAW_EVENTS, FLAW_CUT, FLAW_TAIL} flaw_type;

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [7:0]                        req_tdata  = '0;   // data_byte
   logic                              req_tuser  = 1'b0; // has_byte
   logic                              req_tlast  = 1'b0; // end_of_buffer
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [7:0]                        rsp_tdata;         // verdict_ok, error_reason[2:0]
   logic                              csr_we     = 1'b0;
   logic [srsv_pkg::CSR_INDEX_W-1:0]  csr_index  = '0;
   logic [srsv_pkg::CSR_DATA_W-1:0]   csr_wdata  = '0;

   int fail_count, pending, verdicts, passes;
   int cycles      = 0;
   int gap_pct     = IDLE_PCT;
   int stall_pct   = IDLE_PCT;
   int items_sent  = 0;
   int ends_sent   = 0;
   int settings    = 0;

   logic [srsv_pkg::REC_CNT_W-1:0] rec_limit;
   logic [srsv_pkg::EVENTS_W-1:0]  ev_limit;
   logic [7:0]                     buf_q[$];

   snapshot_record_stream_validator_core #(
      .HEADER_BYTES(HEADER_BYTES),
      .KEY_BYTES   (KEY_BYTES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   srsv_checker #(
      .HEADER_BYTES(HEADER_BYTES),
      .KEY_BYTES   (KEY_BYTES)
   ) u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fail_count(fail_count),
      .pending   (pending),
      .verdicts  (verdicts),
      .passes    (passes)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d verdicts still pending", cycles, pending);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic push_item(input logic has, input logic [7:0] b, input logic last);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= has;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      if (has || last) items_sent++;
      if (last) ends_sent++;
   endtask

   // hold until every verdict is back, then let the pipeline drain
   task automatic wait_idle();
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input logic [srsv_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [srsv_pkg::CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_regs(input logic [srsv_pkg::REC_CNT_W-1:0] rc,
                           input logic [srsv_pkg::EVENTS_W-1:0] me);
      req_tvalid <= 1'b0;
      wait_idle();
      write_reg(srsv_pkg::CSR_RECORD_COUNT, rc);
      write_reg(srsv_pkg::CSR_MAX_EVENTS, srsv_pkg::CSR_DATA_W'(me));
      rec_limit = rc;
      ev_limit  = me;
      settings++;
   endtask

   task automatic push_header(input logic [15:0] key, input logic [15:0] ev);
      buf_q.push_back(key[7:0]);
      buf_q.push_back(key[15:8]);
      buf_q.push_back(ev[7:0]);
      buf_q.push_back(ev[15:8]);
      repeat (HEADER_BYTES - 4) buf_q.push_back(8'($urandom));
   endtask

   // fill buf_q with one buffer: mostly well-formed records, some flawed or pure noise
   task automatic build_buffer();
      int          nrec;
      int          target;
      int          cut;
      flaw_type    flaw;
      logic [15:0] key;
      logic [15:0] ev;
      buf_q.delete();
      if ($urandom_range(99) < 12) begin
         repeat ($urandom_range(0, 20)) buf_q.push_back(8'($urandom));
         return;
      end
      nrec   = (rec_limit <= 6) ? int'(rec_limit) : $urandom_range(0, 3);
      flaw   = ($urandom_range(99) < 30) ? flaw_type'($urandom_range(1, 4)) : FLAW_NONE;
      target = (nrec > 0) ? $urandom_range(0, nrec - 1) : 0;
      for (int r = 0; r < nrec; r++) begin
         key = KEY_BYTES[15:0];
         ev  = 16'($urandom_range(0, (ev_limit < 3) ? int'(ev_limit) : 3));
         if (r == target && flaw == FLAW_KEY) begin
            key = key ^ (16'h1 << $urandom_range(0, 15));
         end else if (r == target && flaw == FLAW_EVENTS && ev_limit != 16'hFFFF) begin
            ev = $urandom_range(1) ? 16'hFFFF : ev_limit + 1'b1;
         end
         push_header(key, ev);
         // after a header error the rest is ignored: add a little junk and stop
         if (key != KEY_BYTES[15:0] || ev > ev_limit) begin
            repeat ($urandom_range(0, 4)) buf_q.push_back(8'($urandom));
            break;
         end
         repeat (KEY_BYTES + 8 * int'(ev)) buf_q.push_back(8'($urandom));
      end
      if (flaw == FLAW_CUT && buf_q.size() > 0) begin
         cut = $urandom_range(1, buf_q.size());
         repeat (cut) void'(buf_q.pop_back());
      end else if (flaw == FLAW_TAIL) begin
         repeat ($urandom_range(1, 3)) buf_q.push_back(8'($urandom));
      end
   endtask

   task automatic send_buffer();
      logic end_on_byte;
      end_on_byte = (buf_q.size() != 0) && ($urandom_range(1) == 1);
      foreach (buf_q[i]) begin
         if ($urandom_range(99) < 4) push_item(1'b0, 8'($urandom), 1'b0);
         push_item(1'b1, buf_q[i], end_on_byte && (i == buf_q.size() - 1));
      end
      if (!end_on_byte) push_item(1'b0, 8'($urandom), 1'b1);
   endtask

   initial begin
      logic [srsv_pkg::REC_CNT_W-1:0] rc;
      logic [srsv_pkg::EVENTS_W-1:0]  me;
      int item_base;
      int phase_no;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty snapshot passes, any byte after it is trailing
      set_regs('0, '0);
      push_item(1'b0, 8'h00, 1'b1);
      push_item(1'b1, 8'hFF, 1'b1);

      // key length and event count both bad: key error wins
      set_regs(32'd1, 16'd0);
      buf_q.delete();
      push_header(16'h0000, 16'hFFFF);
      foreach (buf_q[i]) push_item(1'b1, 8'h00 | buf_q[i], i == buf_q.size() - 1);

      // largest counts, end inside the payload, then end inside a header
      set_regs(32'hFFFF_FFFF, 16'hFFFF);
      push_item(1'b1, KEY_BYTES[7:0], 1'b0);
      push_item(1'b1, KEY_BYTES[15:8], 1'b0);
      push_item(1'b1, 8'hFF, 1'b0);
      push_item(1'b1, 8'hFF, 1'b0);
      push_item(1'b1, 8'h55, 1'b0);
      push_item(1'b1, 8'hAA, 1'b0);
      push_item(1'b1, 8'h0F, 1'b0);
      push_item(1'b1, 8'hF0, 1'b0);
      push_item(1'b1, 8'h00, 1'b1);
      push_item(1'b0, 8'h5A, 1'b0);
      push_item(1'b1, KEY_BYTES[7:0], 1'b0);
      push_item(1'b1, KEY_BYTES[15:8], 1'b0);
      push_item(1'b1, 8'h01, 1'b1);

      item_base = items_sent;
      phase_no  = 0;
      while (items_sent - item_base < RANDOM_ITEMS) begin
         case ($urandom_range(9))
            7:       rc = 32'hFFFF_FFFF;
            8:       rc = $urandom;
            9:       rc = srsv_pkg::REC_CNT_W'($urandom_range(4, 6));
            default: rc = srsv_pkg::REC_CNT_W'($urandom_range(0, 3));
         endcase
         case ($urandom_range(9))
            6:       me = '0;
            7:       me = 16'hFFFF;
            8, 9:    me = 16'($urandom);
            default: me = 16'($urandom_range(0, 4));
         endcase
         set_regs(rc, me);
         // a stretch with no idling on either side
         gap_pct   = (phase_no >= 4 && phase_no < 8) ? 0 : IDLE_PCT;
         stall_pct = gap_pct;
         repeat ($urandom_range(1, 4)) begin
            build_buffer();
            send_buffer();
         end
         phase_no++;
      end

      req_tvalid <= 1'b0;
      wait_idle();
      repeat (10) @(posedge clock);

      $display("Summary: %0d input transactions in %0d buffers, %0d verdicts checked",
               items_sent, ends_sent, verdicts);
      $display("Summary: %0d passing verdicts, %0d register settings, %0d failures",
               passes, settings, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
